// ----- hw/rtl/slab_allocator_table_core_defines.svh -----
// Assertion macros used by the block's datapath module.
`ifndef SLAB_ALLOCATOR_TABLE_CORE_DEFINES_SVH
`define SLAB_ALLOCATOR_TABLE_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SAT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slab allocator table assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slab allocator table assertion failed");

`endif

// ----- hw/rtl/sat_pkg.sv -----
`timescale 1ns / 1ps
package sat_pkg;

   localparam int SLAB_BYTES  = 16384;
   localparam int HANDLE_BITS = 16;
   localparam logic [16:0] SLAB_LIMIT = 17'(SLAB_BYTES);
   localparam logic [14:0] MAX_SIZE_RESET = 15'd1024;

   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [1:0] ST_UNKNOWN  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] size;
      logic [15:0] slab_handle;
      logic [13:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_handle;
      logic [13:0] result_offset;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [14:0]            object_size;
      logic [14:0]            in_use;
      logic [14:0]            bump_offset;
   } slot_type;

   typedef enum logic [2:0] {
      RES_BAD_SIZE,
      RES_UNKNOWN,
      RES_ECHO_OK,
      RES_ECHO_BAD
   } res_sel_type;

   typedef struct packed {
      logic        accept;
      logic        scan_clr;
      logic        scan_inc;
      logic        alloc_hit;
      logic        alloc_new;
      logic        dec_use;
      logic        compact;
      logic        count_dec;
      logic        set_post;
      logic        rd_next;
      logic        res_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       size_bad;
      logic       grow_bad;
      logic       scan_end;
      logic       alloc_match;
      logic       find_match;
      logic       shrink;
      logic       use_gt1;
      logic       compact_more;
      logic       post;
   } stat_type;

endpackage

// ----- hw/rtl/slab_allocator_table_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (sat_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (sat_pkg::rsp_type)
// csr       in         csr_wr_en              csr_wr_data (max_object_size)
//
// One request at a time; each scan of the slot table visits one slot per cycle.
// The longest request is a growing resize: it finds the old slab, allocates, then finds
// the old slab again and frees it, compacting the table when that was its last use.
// Synchronous reset empties the table and restores max_object_size to 1024.
// The response is held in a register until rsp_ready; no new request is taken before then.
module slab_allocator_table_core #(
   parameter int SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sat_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [14:0]      csr_wr_data
);
   import sat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sat_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ----- hw/rtl/sat_ctrl.sv -----
`timescale 1ns / 1ps
module sat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sat_pkg::stat_type stat,
   output sat_pkg::cmd_type  cmd
);
   import sat_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_ASCAN    = 8'b0000_0100,
      S_ANEW     = 8'b0000_1000,
      S_FSCAN    = 8'b0001_0000,
      S_FREE     = 8'b0010_0000,
      S_COMPACT  = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = RES_BAD_SIZE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.action == ACT_ALLOC) begin
               if (stat.size_bad) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_BAD_SIZE;
                  state_in     = S_RESP;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_ASCAN;
               end
            end else if (stat.action == ACT_FREE || stat.action == ACT_RESIZE) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_FSCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ASCAN: begin
            if (stat.scan_end) begin
               state_in = S_ANEW;
            end else if (stat.alloc_match) begin
               cmd.alloc_hit = 1'b1;
               cmd.scan_clr  = stat.post;
               state_in      = stat.post ? S_FSCAN : S_RESP;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_ANEW: begin
            cmd.alloc_new = 1'b1;
            cmd.scan_clr  = stat.post;
            state_in      = stat.post ? S_FSCAN : S_RESP;
         end
         S_FSCAN: begin
            if (stat.scan_end) begin
               cmd.res_load = !stat.post;
               cmd.res_sel  = RES_UNKNOWN;
               state_in     = S_RESP;
            end else if (stat.find_match) begin
               if (stat.action == ACT_FREE || stat.post) begin
                  state_in = S_FREE;
               end else if (stat.shrink) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_ECHO_OK;
                  state_in     = S_RESP;
               end else if (stat.grow_bad) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_ECHO_BAD;
                  state_in     = S_RESP;
               end else begin
                  cmd.set_post = 1'b1;
                  cmd.scan_clr = 1'b1;
                  state_in     = S_ASCAN;
               end
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_FREE: begin
            if (stat.use_gt1) begin
               cmd.dec_use = 1'b1;
               state_in    = S_RESP;
            end else begin
               state_in = S_COMPACT;
            end
         end
         S_COMPACT: begin
            cmd.rd_next = 1'b1;
            if (stat.compact_more) begin
               cmd.compact = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/sat_datapath.sv -----
`timescale 1ns / 1ps
`include "slab_allocator_table_core_defines.svh"
module sat_datapath #(
   parameter int SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [14:0]       csr_wr_data,
   input  sat_pkg::req_type  req_data,
   output sat_pkg::rsp_type  rsp_data,
   input  sat_pkg::cmd_type  cmd,
   output sat_pkg::stat_type stat
);
   import sat_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   slot_type               slots_ff [SLOTS];
   logic [CW-1:0]          idx_ff, idx_in, count_ff, count_in;
   logic [IW-1:0]          victim_ff, victim_in;
   logic [14:0]            min_ff, min_in;
   logic [14:0]            max_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic                   post_ff;
   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in;

   logic [IW-1:0] rd_addr, wr_addr, new_addr;
   slot_type      rd, wr_data;
   logic          wr_en, full;
   logic [16:0]   bump_sum;
   logic [CW:0]   idx_next;

   assign idx_next = {1'b0, idx_ff} + (CW + 1)'(1);
   assign rd_addr  = cmd.rd_next ? IW'(idx_next) : idx_ff[IW-1:0];
   assign rd       = slots_ff[rd_addr];
   assign full     = (count_ff == SLOTS_C);
   assign new_addr = full ? victim_ff : count_ff[IW-1:0];
   assign bump_sum = {2'b0, rd.bump_offset} + {2'b0, req_ff.size};

   assign stat.action       = req_ff.action;
   assign stat.size_bad     = (req_ff.size == 15'd0) || (req_ff.size > max_ff);
   assign stat.grow_bad     = (req_ff.size > max_ff);
   assign stat.scan_end     = (idx_ff >= count_ff);
   assign stat.alloc_match  = (rd.object_size == req_ff.size) && (bump_sum <= SLAB_LIMIT);
   assign stat.find_match   = (rd.handle == req_ff.slab_handle)
                              && ({3'b0, req_ff.byte_offset} < SLAB_LIMIT);
   assign stat.shrink       = (req_ff.size <= rd.object_size);
   assign stat.use_gt1      = (rd.in_use > 15'd1);
   assign stat.compact_more = (idx_next < {1'b0, count_ff});
   assign stat.post         = post_ff;

   assign rsp_data = rsp_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[IW-1:0];
      wr_data = rd;
      if (cmd.alloc_hit) begin
         wr_en               = 1'b1;
         wr_data.in_use      = rd.in_use + 15'd1;
         wr_data.bump_offset = bump_sum[14:0];
      end else if (cmd.alloc_new) begin
         wr_en   = 1'b1;
         wr_addr = new_addr;
         wr_data = '{handle: handle_ff, object_size: req_ff.size,
                     in_use: 15'd1, bump_offset: req_ff.size};
      end else if (cmd.dec_use) begin
         wr_en          = 1'b1;
         wr_data.in_use = rd.in_use - 15'd1;
      end else if (cmd.compact) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      victim_in = victim_ff;
      min_in    = min_ff;
      count_in  = count_ff;
      if (cmd.scan_clr || cmd.accept) begin
         idx_in = '0;
      end else if (cmd.scan_inc || cmd.compact) begin
         idx_in = idx_next[CW-1:0];
      end
      if (cmd.scan_inc && ((idx_ff == '0) || (rd.in_use < min_ff))) begin
         min_in    = rd.in_use;
         victim_in = idx_ff[IW-1:0];
      end
      if (cmd.alloc_new && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.accept) begin
         rsp_in = '0;
      end else if (cmd.alloc_hit) begin
         rsp_in = '{status: ST_OK, result_handle: rd.handle,
                    result_offset: rd.bump_offset[13:0]};
      end else if (cmd.alloc_new) begin
         rsp_in = '{status: ST_OK, result_handle: handle_ff, result_offset: 14'd0};
      end else if (cmd.res_load) begin
         unique case (cmd.res_sel)
            RES_BAD_SIZE: rsp_in = '{status: ST_BAD_SIZE, result_handle: 16'd0,
                                     result_offset: 14'd0};
            RES_UNKNOWN:  rsp_in = '{status: ST_UNKNOWN, result_handle: 16'd0,
                                     result_offset: 14'd0};
            RES_ECHO_OK:  rsp_in = '{status: ST_OK, result_handle: req_ff.slab_handle,
                                     result_offset: req_ff.byte_offset};
            RES_ECHO_BAD: rsp_in = '{status: ST_BAD_SIZE,
                                     result_handle: req_ff.slab_handle,
                                     result_offset: req_ff.byte_offset};
            default:      rsp_in = rsp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      rsp_ff    <= rsp_in;
      victim_ff <= victim_in;
      min_ff    <= min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         count_ff  <= '0;
         handle_ff <= '0;
         post_ff   <= 1'b0;
         max_ff    <= MAX_SIZE_RESET;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         if (cmd.alloc_new) begin
            handle_ff <= handle_ff + HANDLE_BITS'(1);
         end
         if (cmd.accept) begin
            post_ff <= 1'b0;
         end else if (cmd.set_post) begin
            post_ff <= 1'b1;
         end
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   `SAT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= SLOTS_C)
   `SAT_ASSERT_NOW(a_dec_nonempty, clock, reset, cmd.count_dec, count_ff != '0)
   `SAT_ASSERT_NEXT(a_handle_step, clock, reset, cmd.alloc_new,
                    handle_ff == $past(handle_ff) + HANDLE_BITS'(1))

endmodule
